FILE: rtl/core/sph_dens_pkg.sv
package sph_dens_pkg;

   // Field and datapath widths
   localparam int DEF_POS_BITS  = 20;
   localparam int RADIUS_BITS   = 20;
   localparam int SCALE_BITS    = 32;
   localparam int DENS_BITS     = 32;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = 1;
   localparam int MUL_BITS      = 32;
   localparam int PROD_BITS     = 2 * MUL_BITS;
   localparam int SQ_BITS       = 2 * RADIUS_BITS + 2;
   localparam int ROOT_ITERS    = SQ_BITS / 2;
   localparam int CNT_BITS      = $clog2(ROOT_ITERS);
   localparam int TERM_SHIFT    = 8;
   localparam int STEP_BITS     = 4;

   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(2560);
   localparam logic [SCALE_BITS-1:0]  SCALE_RESET  = '0;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_KERNEL_RADIUS = 1'b0,
      CSR_KERNEL_SCALE  = 1'b1
   } csr_idx_type;

   // Datapath operations, one per control word
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LATCH,
      OP_DELTA,
      OP_MUL_DXDX,
      OP_MUL_DYDY,
      OP_ROOT_INIT,
      OP_ROOT_STEP,
      OP_FACTOR,
      OP_MUL_FF,
      OP_MUL_F2LO,
      OP_MUL_F2HI,
      OP_CUBE_ADD,
      OP_MUL_CLO,
      OP_MUL_CHI,
      OP_TERM_ADD,
      OP_ACCUM
   } dp_op_type;

   // Branch conditions, one per control word
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_WAIT_REQ,
      COND_JMP_FAR,
      COND_LOOP,
      COND_JMP_OUTSIDE,
      COND_WAIT_RSP
   } cond_type;

   typedef enum logic [STEP_BITS-1:0] {
      S_IDLE,
      S_DELTA,
      S_SQX,
      S_SQY,
      S_SUM,
      S_ROOT,
      S_FACT,
      S_CUBE_FF,
      S_CUBE_LO,
      S_CUBE_HI,
      S_CUBE_ADD,
      S_TERM_LO,
      S_TERM_HI,
      S_TERM_ADD,
      S_ACCUM,
      S_FINISH
   } step_type;

   typedef struct packed {
      dp_op_type op;
      logic      emit;
      cond_type  cond;
      step_type  target;
      logic      load_cnt;
   } uword_type;

   // Control signals from sequencer to datapath
   typedef struct packed {
      dp_op_type op;
      logic      emit;
   } ctrl_type;

   // Status flags from datapath to sequencer
   typedef struct packed {
      logic far;
      logic outside;
      logic out_busy;
   } status_type;

   // Microcode program
   function automatic uword_type ucode_rom(step_type s);
      uword_type w;
      w = '{op: OP_NOP, emit: 1'b0, cond: COND_NEXT, target: S_IDLE, load_cnt: 1'b0};
      unique case (s)
         S_IDLE: begin
            w.op = OP_LATCH;  w.cond = COND_WAIT_REQ;
         end
         S_DELTA: begin
            w.op = OP_DELTA;  w.cond = COND_JMP_FAR;  w.target = S_FINISH;
         end
         S_SQX:      w.op = OP_MUL_DXDX;
         S_SQY:      w.op = OP_MUL_DYDY;
         S_SUM: begin
            w.op = OP_ROOT_INIT;  w.load_cnt = 1'b1;
         end
         S_ROOT: begin
            w.op = OP_ROOT_STEP;  w.cond = COND_LOOP;  w.target = S_ROOT;
         end
         S_FACT: begin
            w.op = OP_FACTOR;  w.cond = COND_JMP_OUTSIDE;  w.target = S_FINISH;
         end
         S_CUBE_FF:  w.op = OP_MUL_FF;
         S_CUBE_LO:  w.op = OP_MUL_F2LO;
         S_CUBE_HI:  w.op = OP_MUL_F2HI;
         S_CUBE_ADD: w.op = OP_CUBE_ADD;
         S_TERM_LO:  w.op = OP_MUL_CLO;
         S_TERM_HI:  w.op = OP_MUL_CHI;
         S_TERM_ADD: w.op = OP_TERM_ADD;
         S_ACCUM:    w.op = OP_ACCUM;
         S_FINISH: begin
            w.emit = 1'b1;  w.cond = COND_WAIT_RSP;  w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/core/sph_dens_req_if.sv
interface sph_dens_req_if #(
   parameter int POS_BITS = sph_dens_pkg::DEF_POS_BITS
);
   logic                valid;
   logic                ready;
   logic [POS_BITS-1:0] center_x;
   logic [POS_BITS-1:0] center_y;
   logic [POS_BITS-1:0] neighbour_x;
   logic [POS_BITS-1:0] neighbour_y;
   logic                neighbour_present;
   logic                last_neighbour;

   modport source (
      output valid, center_x, center_y, neighbour_x, neighbour_y,
             neighbour_present, last_neighbour,
      input  ready
   );
   modport sink (
      input  valid, center_x, center_y, neighbour_x, neighbour_y,
             neighbour_present, last_neighbour,
      output ready
   );
endinterface

FILE: rtl/core/sph_dens_rsp_if.sv
interface sph_dens_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [sph_dens_pkg::DENS_BITS-1:0] density;
   logic                             saturated;

   modport source (output valid, density, saturated, input ready);
   modport sink   (input valid, density, saturated, output ready);
endinterface

FILE: rtl/core/sph_dens_seq.sv
module sph_dens_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  sph_dens_pkg::status_type status,
   output logic                    req_ready,
   output sph_dens_pkg::ctrl_type  ctrl
);

   sph_dens_pkg::step_type                 step_ff, step_in;
   logic [sph_dens_pkg::CNT_BITS-1:0]      cnt_ff, cnt_in;
   sph_dens_pkg::uword_type                word;

   // Step counter and loop counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= sph_dens_pkg::S_IDLE;
         cnt_ff  <= '0;
      end else begin
         step_ff <= step_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Fetch the control word, resolve the branch
   always_comb begin
      word      = sph_dens_pkg::ucode_rom(step_ff);
      ctrl.op   = word.op;
      ctrl.emit = word.emit;
      req_ready = 1'b0;
      step_in   = sph_dens_pkg::step_type'(
                     sph_dens_pkg::STEP_BITS'(step_ff + 1'b1));
      cnt_in    = cnt_ff;
      unique case (word.cond)
         sph_dens_pkg::COND_NEXT: ;
         sph_dens_pkg::COND_WAIT_REQ: begin
            // take no word while reset is high
            req_ready = !reset;
            if (!req_valid || reset) begin
               step_in = step_ff;
               ctrl.op = sph_dens_pkg::OP_NOP;
            end
         end
         sph_dens_pkg::COND_JMP_FAR: begin
            if (status.far) step_in = word.target;
         end
         sph_dens_pkg::COND_LOOP: begin
            if (cnt_ff != '0) begin
               cnt_in  = cnt_ff - 1'b1;
               step_in = word.target;
            end
         end
         sph_dens_pkg::COND_JMP_OUTSIDE: begin
            if (status.outside) step_in = word.target;
         end
         sph_dens_pkg::COND_WAIT_RSP: begin
            if (status.out_busy) begin
               step_in   = step_ff;
               ctrl.emit = 1'b0;
            end else begin
               step_in = word.target;
            end
         end
         default: ;
      endcase
      if (word.load_cnt) begin
         cnt_in = sph_dens_pkg::CNT_BITS'(sph_dens_pkg::ROOT_ITERS - 1);
      end
   end

endmodule

FILE: rtl/core/sph_dens_datapath.sv
module sph_dens_datapath #(
   parameter int POS_BITS = sph_dens_pkg::DEF_POS_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   sph_dens_req_if.sink                           req_chan,
   sph_dens_rsp_if.source                         rsp_chan,
   input  logic [sph_dens_pkg::RADIUS_BITS-1:0]   kernel_radius,
   input  logic [sph_dens_pkg::SCALE_BITS-1:0]    kernel_scale,
   input  sph_dens_pkg::ctrl_type                 ctrl,
   output sph_dens_pkg::status_type               status
);

   localparam int RB   = sph_dens_pkg::RADIUS_BITS;
   localparam int MB   = sph_dens_pkg::MUL_BITS;
   localparam int PB   = sph_dens_pkg::PROD_BITS;
   localparam int SB   = sph_dens_pkg::SQ_BITS;
   localparam int DB   = sph_dens_pkg::DENS_BITS;
   localparam int SH   = sph_dens_pkg::TERM_SHIFT;
   localparam int CMPB = (POS_BITS > RB) ? POS_BITS : RB;
   localparam int F2HB = 2 * RB - MB;

   // Latched input word
   logic [POS_BITS-1:0] cx_ff, cy_ff, nx_ff, ny_ff;
   logic                present_ff, last_ff;

   // Working registers
   logic [RB-1:0]   dx_ff, dy_ff, f_ff;
   logic [PB-1:0]   p_ff, c_ff;
   logic [SB-1:0]   v_ff, root_ff, bit_ff;
   logic [F2HB-1:0] f2hi_ff;
   logic [MB-1:0]   lohi_ff;

   // Accumulator and output word
   logic [DB-1:0]   sum_ff;
   logic            clip_ff;
   logic            rsp_valid_ff;
   logic [DB-1:0]   rsp_density_ff;
   logic            rsp_sat_ff;

   logic [POS_BITS-1:0] dx_full, dy_full;
   logic [CMPB-1:0]     dx_cmp, dy_cmp, r_cmp;
   logic [MB-1:0]       mul_a, mul_b;
   logic [PB-1:0]       mul_p;
   logic [SB-1:0]       trial;
   logic [DB-1:0]       term;
   logic [DB:0]         sum_wide;

   // Deltas and far test
   always_comb begin
      dx_full = (cx_ff >= nx_ff) ? (cx_ff - nx_ff) : (nx_ff - cx_ff);
      dy_full = (cy_ff >= ny_ff) ? (cy_ff - ny_ff) : (ny_ff - cy_ff);
      dx_cmp  = CMPB'(dx_full);
      dy_cmp  = CMPB'(dy_full);
      r_cmp   = CMPB'(kernel_radius);
   end

   assign status.far      = !present_ff || (dx_cmp >= r_cmp) || (dy_cmp >= r_cmp);
   assign status.outside  = (root_ff >= SB'(kernel_radius));
   assign status.out_busy = last_ff && rsp_valid_ff && !rsp_chan.ready;

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctrl.op)
         sph_dens_pkg::OP_MUL_DXDX: begin
            mul_a = MB'(dx_ff);  mul_b = MB'(dx_ff);
         end
         sph_dens_pkg::OP_MUL_DYDY: begin
            mul_a = MB'(dy_ff);  mul_b = MB'(dy_ff);
         end
         sph_dens_pkg::OP_MUL_FF: begin
            mul_a = MB'(f_ff);  mul_b = MB'(f_ff);
         end
         sph_dens_pkg::OP_MUL_F2LO: begin
            mul_a = p_ff[MB-1:0];  mul_b = MB'(f_ff);
         end
         sph_dens_pkg::OP_MUL_F2HI: begin
            mul_a = MB'(f2hi_ff);  mul_b = MB'(f_ff);
         end
         sph_dens_pkg::OP_MUL_CLO: begin
            mul_a = c_ff[MB-1:0];  mul_b = kernel_scale;
         end
         sph_dens_pkg::OP_MUL_CHI: begin
            mul_a = c_ff[PB-1:MB];  mul_b = kernel_scale;
         end
         default: ;
      endcase
   end

   // Shared 32x32 multiplier, full product
   assign mul_p = PB'(mul_a) * PB'(mul_b);

   // Root trial, term saturation and saturating sum
   always_comb begin
      trial    = root_ff + bit_ff;
      term     = (c_ff[PB-1:DB+SH] != '0) ? '1 : c_ff[DB+SH-1:SH];
      sum_wide = {1'b0, sum_ff} + {1'b0, term};
   end

   // Payload registers
   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         sph_dens_pkg::OP_LATCH: begin
            cx_ff      <= req_chan.center_x;
            cy_ff      <= req_chan.center_y;
            nx_ff      <= req_chan.neighbour_x;
            ny_ff      <= req_chan.neighbour_y;
            present_ff <= req_chan.neighbour_present;
            last_ff    <= req_chan.last_neighbour;
         end
         sph_dens_pkg::OP_DELTA: begin
            dx_ff <= RB'(dx_cmp);
            dy_ff <= RB'(dy_cmp);
         end
         sph_dens_pkg::OP_MUL_DXDX: p_ff <= mul_p;
         sph_dens_pkg::OP_MUL_DYDY: begin
            v_ff <= SB'(p_ff);
            p_ff <= mul_p;
         end
         sph_dens_pkg::OP_ROOT_INIT: begin
            v_ff    <= v_ff + SB'(p_ff);
            root_ff <= '0;
            bit_ff  <= SB'(1) << (SB - 2);
         end
         sph_dens_pkg::OP_ROOT_STEP: begin
            if (v_ff >= trial) begin
               v_ff    <= v_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         sph_dens_pkg::OP_FACTOR: f_ff <= kernel_radius - root_ff[RB-1:0];
         sph_dens_pkg::OP_MUL_FF: p_ff <= mul_p;
         sph_dens_pkg::OP_MUL_F2LO: begin
            f2hi_ff <= p_ff[2*RB-1:MB];
            p_ff    <= mul_p;
         end
         sph_dens_pkg::OP_MUL_F2HI: begin
            c_ff <= p_ff;
            p_ff <= mul_p;
         end
         sph_dens_pkg::OP_CUBE_ADD: c_ff <= c_ff + {p_ff[MB-1:0], {MB{1'b0}}};
         sph_dens_pkg::OP_MUL_CLO:  p_ff <= mul_p;
         sph_dens_pkg::OP_MUL_CHI: begin
            lohi_ff <= p_ff[PB-1:MB];
            p_ff    <= mul_p;
         end
         sph_dens_pkg::OP_TERM_ADD: c_ff <= p_ff + PB'(lohi_ff);
         default: ;
      endcase
      if (ctrl.emit && last_ff) begin
         rsp_density_ff <= sum_ff;
         rsp_sat_ff     <= clip_ff;
      end
   end

   // Accumulator and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit && last_ff) begin
         // hand the sum to the output word and clear it
         rsp_valid_ff <= 1'b1;
         sum_ff       <= '0;
         clip_ff      <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) rsp_valid_ff <= 1'b0;
         if (ctrl.op == sph_dens_pkg::OP_ACCUM) begin
            if (sum_wide[DB]) begin
               sum_ff  <= '1;
               clip_ff <= 1'b1;
            end else begin
               sum_ff <= sum_wide[DB-1:0];
            end
         end
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.density   = rsp_density_ff;
   assign rsp_chan.saturated = rsp_sat_ff;

endmodule

FILE: rtl/core/sph_density_accumulate_top.sv
// SPH density accumulator, 2-D spiky cubic kernel.
// req_chan carries one neighbour word: centre and neighbour positions (Q12.8),
// a presence flag and a last flag. Present neighbours inside kernel_radius
// add (radius - distance)^3 * kernel_scale to a saturating Q16.16 sum. The
// word flagged last returns one rsp_chan word (density, saturated) and
// clears the sum; other words return nothing.
// The block takes one word at a time. A neighbour inside the radius runs
// every step from accept to the next accept: the 21-step shift-subtract
// square root dominates, with 7 passes through the shared 32x32 multiplier.
// An absent or far neighbour jumps from the delta step to the finish step;
// one the root places outside the radius jumps from the factor step. The
// result word is registered, valid in the cycle after the finish step.
// If rsp_chan stalls, the result stays registered; further non-last words
// are still taken, and the block waits only when a new result is due.
// Configuration: csr_write_en with csr_index 0 (kernel_radius, reset 2560)
// or 1 (kernel_scale, reset 0); write only while the block is idle.
// reset is synchronous and clears the sum, the sequencer and the output;
// req_chan takes no word while reset is high.
module sph_density_accumulate_top #(
   parameter int POS_BITS = sph_dens_pkg::DEF_POS_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   sph_dens_req_if.sink                             req_chan,
   sph_dens_rsp_if.source                           rsp_chan,
   input  logic                                     csr_write_en,
   input  logic [sph_dens_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [sph_dens_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   logic [sph_dens_pkg::RADIUS_BITS-1:0] kernel_radius_ff;
   logic [sph_dens_pkg::SCALE_BITS-1:0]  kernel_scale_ff;
   sph_dens_pkg::ctrl_type               ctrl;
   sph_dens_pkg::status_type             status;
   logic                                 req_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_radius_ff <= sph_dens_pkg::RADIUS_RESET;
         kernel_scale_ff  <= sph_dens_pkg::SCALE_RESET;
      end else if (csr_write_en) begin
         unique case (sph_dens_pkg::csr_idx_type'(csr_index))
            sph_dens_pkg::CSR_KERNEL_RADIUS:
               kernel_radius_ff <= csr_data[sph_dens_pkg::RADIUS_BITS-1:0];
            sph_dens_pkg::CSR_KERNEL_SCALE:
               kernel_scale_ff <= csr_data[sph_dens_pkg::SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = req_ready;

   sph_dens_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   sph_dens_datapath #(
      .POS_BITS (POS_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .kernel_radius (kernel_radius_ff),
      .kernel_scale  (kernel_scale_ff),
      .ctrl          (ctrl),
      .status        (status)
   );

endmodule
